[rtl/core/wcag_contrast_ratio_core_assert.svh]
// Assertion macros used by the contrast ratio checker
`ifndef WCAG_CONTRAST_RATIO_CORE_ASSERT_SVH
`define WCAG_CONTRAST_RATIO_CORE_ASSERT_SVH

// clocked check, quiet while reset is asserted
`define WCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check, quiet while reset is asserted
`define WCR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/wcr_pkg.sv]
// Shared constants, types and the linearization table of the contrast ratio core
package wcr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CODE_W    = 8;
    localparam int LIN_W     = FRAC_BITS + 1;
    localparam int Q_W       = 21;
    localparam int NUM_W     = LIN_W + FRAC_BITS;
    localparam int SUM_W     = LIN_W + FRAC_BITS + 2;
    localparam int TAB_N     = 1 << CODE_W;

    localparam longint ONE   = longint'(1) << FRAC_BITS;
    localparam longint K_OFF = (ONE + 10) / 20;
    localparam longint WR    = (2126 * ONE + 5000) / 10000;
    localparam longint WG    = (7152 * ONE + 5000) / 10000;
    localparam longint WB    = (722 * ONE + 5000) / 10000;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [LIN_W-1:0]  lin_t;
    typedef logic [Q_W-1:0]    quo_t;
    typedef lin_t lin_tab_t [TAB_N];

    // one division cell's worth of state
    typedef struct packed {
        lin_t rem;
        quo_t nlo;
        lin_t den;
        quo_t q;
    } div_t;

    function automatic lin_tab_t build_tab();
        lin_tab_t tab;
        real      t;
        longint   v;
        for (int c = 0; c < TAB_N; c++)
        begin
            if (c <= 10)
            begin
                v = ((longint'(c) * 10 * ONE) + 16473) / 32946;
            end
            else
            begin
                t = (real'(c) / 255.0 + 0.055) / 1.055;
                v = longint'($rtoi((t ** 2.4) * real'(ONE) + 0.5));
            end
            if (c == TAB_N - 1)
            begin
                v = ONE;
            end
            tab[c] = lin_t'(v);
        end
        return tab;
    endfunction

    localparam lin_tab_t LIN_TABLE = build_tab();

endpackage

[rtl/core/wcr_front.sv]
// Front end: channel linearization, weighted luminance sum, ordering and offset
module wcr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  wcr_pkg::code_t r1,
    input  wcr_pkg::code_t g1,
    input  wcr_pkg::code_t b1,
    input  wcr_pkg::code_t r2,
    input  wcr_pkg::code_t g2,
    input  wcr_pkg::code_t b2,
    output logic           out_valid,
    input  logic           out_ready,
    output wcr_pkg::lin_t  hi_off,
    output wcr_pkg::lin_t  lo_off
);
    import wcr_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    lin_t lr1_reg, lg1_reg, lb1_reg, lr2_reg, lg2_reg, lb2_reg;
    lin_t l1_reg, l2_reg;
    lin_t hi_reg, lo_reg;
    logic [SUM_W-1:0] s1, s2;
    lin_t l1_next, l2_next;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        s1 = SUM_W'(WR) * SUM_W'(lr1_reg) + SUM_W'(WG) * SUM_W'(lg1_reg)
           + SUM_W'(WB) * SUM_W'(lb1_reg) + SUM_W'(ONE >> 1);
        s2 = SUM_W'(WR) * SUM_W'(lr2_reg) + SUM_W'(WG) * SUM_W'(lg2_reg)
           + SUM_W'(WB) * SUM_W'(lb2_reg) + SUM_W'(ONE >> 1);
        l1_next = lin_t'(s1 >> FRAC_BITS);
        l2_next = lin_t'(s2 >> FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            lr1_reg <= LIN_TABLE[r1];
            lg1_reg <= LIN_TABLE[g1];
            lb1_reg <= LIN_TABLE[b1];
            lr2_reg <= LIN_TABLE[r2];
            lg2_reg <= LIN_TABLE[g2];
            lb2_reg <= LIN_TABLE[b2];
        end
        if (en2)
        begin
            l1_reg <= l1_next;
            l2_reg <= l2_next;
        end
        if (en3)
        begin
            hi_reg <= ((l1_reg > l2_reg) ? l1_reg : l2_reg) + lin_t'(K_OFF);
            lo_reg <= ((l1_reg > l2_reg) ? l2_reg : l1_reg) + lin_t'(K_OFF);
        end
    end

    assign out_valid = v3_reg;
    assign hi_off    = hi_reg;
    assign lo_off    = lo_reg;

endmodule

[rtl/core/wcr_div_cell.sv]
// One restoring-division cell: retires one quotient bit per transaction
module wcr_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  wcr_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output wcr_pkg::div_t out_data
);
    import wcr_pkg::*;

    logic           v_reg;
    div_t           d_reg;
    div_t           d_next;
    logic [LIN_W:0] trial;
    logic           ge;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        trial = {in_data.rem, in_data.nlo[Q_W-1]};
        ge    = trial >= {1'b0, in_data.den};
        d_next.rem = ge ? lin_t'(trial - {1'b0, in_data.den}) : lin_t'(trial);
        d_next.nlo = {in_data.nlo[Q_W-2:0], 1'b0};
        d_next.den = in_data.den;
        d_next.q   = {in_data.q[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

[rtl/core/wcag_contrast_ratio_core.sv]
// WCAG 2 contrast ratio of two 8-bit sRGB colors
// Input channel: in_valid/in_stall with the six color codes; a transaction
// completes on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with ratio_q16, unsigned Q5.16, 1.0..21.0.
// Stages: table lookup, weighted sum, ordering plus offset,
// then a row of 21 division cells, one quotient bit per cell.
// Throughput is one color pair per cycle while out_stall is low; every stage holds one transaction
// and moves it on as soon as the stage after it is free.
// When the receiver stalls, the last cell holds its result and stages fill
// up behind it; in_stall rises only once no stage can take a new pair.
// Reset clears all stage valid flags; no results are pending after reset.
module wcag_contrast_ratio_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          first_red,
    input  logic [7:0]          first_green,
    input  logic [7:0]          first_blue,
    input  logic [7:0]          second_red,
    input  logic [7:0]          second_green,
    input  logic [7:0]          second_blue,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [20:0]         ratio_q16
);
    import wcr_pkg::*;

    logic             f_ready, f_valid;
    lin_t             hi_off, lo_off;
    logic [NUM_W-1:0] num;
    logic             cv [Q_W+1];
    logic             cr [Q_W+1];
    div_t             cd [Q_W+1];

    wcr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (f_ready),
        .r1       (first_red),
        .g1       (first_green),
        .b1       (first_blue),
        .r2       (second_red),
        .g2       (second_green),
        .b2       (second_blue),
        .out_valid(f_valid),
        .out_ready(cr[0]),
        .hi_off   (hi_off),
        .lo_off   (lo_off)
    );

    assign in_stall = !f_ready;

    // quotient fits in Q_W bits, so the bits above them stay below the divisor
    assign num       = {hi_off, {FRAC_BITS{1'b0}}};
    assign cv[0]     = f_valid;
    assign cd[0].rem = lin_t'(num[NUM_W-1:Q_W]);
    assign cd[0].nlo = num[Q_W-1:0];
    assign cd[0].den = lo_off;
    assign cd[0].q   = '0;

    for (genvar i = 0; i < Q_W; i++)
    begin : g_cell
        wcr_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (cv[i]),
            .in_ready (cr[i]),
            .in_data  (cd[i]),
            .out_valid(cv[i+1]),
            .out_ready(cr[i+1]),
            .out_data (cd[i+1])
        );
    end

    assign cr[Q_W]   = !out_stall;
    assign out_valid = cv[Q_W];
    assign ratio_q16 = cd[Q_W].q;

endmodule

[rtl/core/wcr_checker.sv]
// Port-level checker for the contrast ratio core, bound to the top level
`include "wcag_contrast_ratio_core_assert.svh"

module wcr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [20:0] ratio_q16
);
    `WCR_ASSERT(a_ratio_min, !out_valid || ratio_q16 >= 21'd65536, "ratio below 1.0")
    `WCR_ASSERT(a_ratio_max, !out_valid || ratio_q16 <= 21'd1376256, "ratio above 21.0")
    `WCR_ASSERT_IMP(a_out_hold, out_valid && out_stall, out_valid && $stable(ratio_q16),
        "stalled result changed")
    // an empty last cell lets every stage move, so the input cannot be stalled
    `WCR_ASSERT(a_no_stall_idle, out_valid || !in_stall,
        "input stalled while output empty")
endmodule

bind wcag_contrast_ratio_core wcr_checker u_wcr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ratio_q16(ratio_q16)
);

[verif/tb.sv]
// Self-checking testbench for the WCAG contrast ratio core
`timescale 1ns / 1ps

module tb;

    import wcr_pkg::*;

    localparam int N_RANDOM   = 1330;
    localparam int N_CALM     = 200;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT = 40;

    // expected contrast ratios for accepted color pairs, oldest first
    class ratio_board;
        logic [16:0] lin_of [256];
        logic [20:0] ratio_due [$];
        int          errors;
        int          checked;

        function automatic logic [16:0] curve_point(int c, logic [383:0] den12);
            logic [383:0] lhs;
            logic [383:0] prod;
            int unsigned  lo;
            int unsigned  hi;
            int unsigned  mid;
            lhs = 384'd1;
            for (int k = 0; k < 12; k++)
                lhs = lhs * 384'(1000 * c + 14025);
            lhs = lhs << (5 * FRAC_BITS + 5);
            lo = 0;
            hi = 1 << FRAC_BITS;
            // largest n with (2n-1)^5 * 269025^12 <= 2^(5F+5) * (1000c+14025)^12
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                prod = den12;
                for (int k = 0; k < 5; k++)
                    prod = prod * 384'(2 * mid - 1);
                if (prod <= lhs)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return 17'(lo);
        endfunction

        function new();
            logic [383:0] den12;
            den12 = 384'd1;
            for (int k = 0; k < 12; k++)
                den12 = den12 * 384'd269025;
            for (int c = 0; c < 256; c++)
            begin
                if (c <= 10)
                    lin_of[c] = 17'(((longint'(c) * 10 << FRAC_BITS) + 16473) / 32946);
                else
                    lin_of[c] = curve_point(c, den12);
            end
            errors = 0;
            checked = 0;
        endfunction

        function automatic longint rel_luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            longint one;
            longint s;
            one = longint'(1) << FRAC_BITS;
            s = ((2126 * one + 5000) / 10000) * longint'(lin_of[r])
              + ((7152 * one + 5000) / 10000) * longint'(lin_of[g])
              + ((722 * one + 5000) / 10000) * longint'(lin_of[b]);
            return (s + (one >> 1)) >> FRAC_BITS;
        endfunction

        function void note_pair(logic [7:0] r1, logic [7:0] g1, logic [7:0] b1,
                                logic [7:0] r2, logic [7:0] g2, logic [7:0] b2);
            longint l1;
            longint l2;
            longint bright;
            longint dark;
            longint k;
            l1 = rel_luma(r1, g1, b1);
            l2 = rel_luma(r2, g2, b2);
            bright = (l1 > l2) ? l1 : l2;
            dark = (l1 > l2) ? l2 : l1;
            k = ((longint'(1) << FRAC_BITS) + 10) / 20;
            ratio_due.push_back(21'(((bright + k) << FRAC_BITS) / (dark + k)));
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_ratio(logic [20:0] got);
            logic [20:0] want;
            checked++;
            if (ratio_due.size() == 0)
            begin
                report($sformatf("ratio %0d with no pair pending", got));
            end
            else
            begin
                want = ratio_due.pop_front();
                if (got !== want)
                    report($sformatf("ratio_q16 got %0d want %0d", got, want));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  first_red;
    logic [7:0]  first_green;
    logic [7:0]  first_blue;
    logic [7:0]  second_red;
    logic [7:0]  second_green;
    logic [7:0]  second_blue;
    logic        out_valid;
    logic        out_stall;
    logic [20:0] ratio_q16;

    ratio_board board;
    bit         calm;
    int         idle_cycles;
    int         pairs_sent;

    wcag_contrast_ratio_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_red    (first_red),
        .first_green  (first_green),
        .first_blue   (first_blue),
        .second_red   (second_red),
        .second_green (second_green),
        .second_blue  (second_blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ratio_q16    (ratio_q16)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 12));
            1: return 8'($urandom_range(250, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    task send_pair(logic [7:0] r1, logic [7:0] g1, logic [7:0] b1,
                   logic [7:0] r2, logic [7:0] g2, logic [7:0] b2);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        first_red    <= r1;
        first_green  <= g1;
        first_blue   <= b1;
        second_red   <= r2;
        second_green <= g2;
        second_blue  <= b2;
        do
            @(posedge clk);
        while (in_stall);
        board.note_pair(r1, g1, b1, r2, g2, b2);
        pairs_sent++;
    endtask

    task send_same(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send_pair(r, g, b, r, g, b);
    endtask

    // receiver back-pressure in bursts
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_ratio(ratio_q16);

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        board = new();
        calm = 1'b0;
        idle_cycles = 0;
        pairs_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        first_red = '0;
        first_green = '0;
        first_blue = '0;
        second_red = '0;
        second_green = '0;
        second_blue = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, both orders, equal luminance, linear segment edge
        send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        send_same(8'd0, 8'd0, 8'd0);
        send_same(8'd255, 8'd255, 8'd255);
        send_same(8'd10, 8'd128, 8'd77);
        send_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0);
        send_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
        send_pair(8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11);
        send_pair(8'd11, 8'd0, 8'd0, 8'd10, 8'd0, 8'd0);
        send_pair(8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
        send_pair(8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255);
        send_pair(8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127);
        send_pair(8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85);
        send_pair(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        for (int b = 0; b < 8; b++)
            send_pair(8'(1 << b), 8'(1 << b), 8'(1 << b), ~8'(1 << b), 8'd0, ~8'(1 << b));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            logic [7:0] r;
            logic [7:0] g;
            logic [7:0] b;
            if (i == N_RANDOM - N_CALM)
                calm = 1'b1;
            r = pick_code();
            g = pick_code();
            b = pick_code();
            if ($urandom_range(0, 9) == 0)
                send_same(r, g, b);
            else
                send_pair(r, g, b, pick_code(), pick_code(), pick_code());
        end
        in_valid <= 1'b0;

        while (board.ratio_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d color pairs sent, %0d ratios checked, %0d mismatches",
                 pairs_sent, board.checked, board.errors);
        $display("covered black/white, equal colors, linear segment edge, random stalls");
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/wcr_pkg.sv
rtl/core/wcr_front.sv
rtl/core/wcr_div_cell.sv
rtl/core/wcag_contrast_ratio_core.sv
rtl/core/wcr_checker.sv
verif/tb.sv
